// File: rtl/rrss_pkg.sv
package rrss_pkg;

  // slot table geometry
  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int OUT_SLOT_W = 4;

  localparam logic [7:0] TIME_SLICE_RST = 8'd16;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SLEEP = 2'd1,
    ACT_EXIT  = 2'd2,
    ACT_FORK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } slot_state_e;

  // input item and result item
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] sleep_ticks;
  } in_item_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] running_slot;
    logic [OUT_SLOT_W-1:0] new_slot;
    logic                  failed;
  } out_item_t;

  // one entry of the slot table
  typedef struct packed {
    slot_state_e state;
    logic [15:0] sleep_left;
    logic [7:0]  slice_used;
  } slot_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd_cur;
    logic load;
    logic scan_rd;
    logic wr_cur;
    logic rd_pick;
    logic wr_pick;
    logic fork_wr;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    action_e action;
    logic    ticks_zero;
    logic    charge;
  } dp_status_t;

  // round robin successor
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] last;
    last = SLOT_W'(NUM_SLOTS - 1);
    return (s == last) ? '0 : s + 1'b1;
  endfunction

  // contents of an entry never written since reset
  function automatic slot_entry_t reset_entry(input logic [SLOT_W-1:0] addr);
    slot_entry_t e;
    e.state      = (addr == '0) ? ST_RUNNING : ST_DEAD;
    e.sleep_left = '0;
    e.slice_used = '0;
    return e;
  endfunction

  // slot number as reported on the result
  function automatic logic [OUT_SLOT_W-1:0] to_out_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+OUT_SLOT_W-1:0] ext;
    ext = {{OUT_SLOT_W{1'b0}}, s};
    return ext[OUT_SLOT_W-1:0];
  endfunction

endpackage

// File: rtl/rrss_ctrl.sv
module rrss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  rrss_pkg::dp_status_t status_i,
  output rrss_pkg::dp_cmd_t    cmd_o,
  output logic                busy,
  output logic                done_o
);
  import rrss_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_TSCAN = 4'd2;
  localparam logic [3:0] S_TLAST = 4'd3;
  localparam logic [3:0] S_WCUR  = 4'd4;
  localparam logic [3:0] S_RPICK = 4'd5;
  localparam logic [3:0] S_WPICK = 4'd6;
  localparam logic [3:0] S_FSCAN = 4'd7;
  localparam logic [3:0] S_FLAST = 4'd8;
  localparam logic [3:0] S_FWR   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [CNT_W-1:0] TICK_LAST = CNT_W'(NUM_SLOTS - 2);
  localparam logic [CNT_W-1:0] FORK_LAST = CNT_W'(NUM_SLOTS - 1);

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          cmd_o.rd_cur = 1'b1;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        if (status_i.action == ACT_FORK) begin
          state_d = S_FSCAN;
        end else if (status_i.action == ACT_SLEEP && status_i.ticks_zero) begin
          state_d = S_DONE;
        end else begin
          state_d = S_TSCAN;
        end
      end
      S_TSCAN: begin
        cmd_o.scan_rd = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == TICK_LAST) begin
          state_d = S_TLAST;
        end
      end
      S_TLAST: begin
        state_d = S_WCUR;
      end
      S_WCUR: begin
        cmd_o.wr_cur = 1'b1;
        state_d      = status_i.charge ? S_DONE : S_RPICK;
      end
      S_RPICK: begin
        cmd_o.rd_pick = 1'b1;
        state_d       = S_WPICK;
      end
      S_WPICK: begin
        cmd_o.wr_pick = 1'b1;
        state_d       = S_DONE;
      end
      S_FSCAN: begin
        cmd_o.scan_rd = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == FORK_LAST) begin
          state_d = S_FLAST;
        end
      end
      S_FLAST: begin
        state_d = S_FWR;
      end
      S_FWR: begin
        cmd_o.fork_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// File: rtl/rrss_datapath.sv
module rrss_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  rrss_pkg::in_item_t   item_i,
  input  rrss_pkg::dp_cmd_t    cmd_i,
  output rrss_pkg::dp_status_t status_o,
  output rrss_pkg::out_item_t  result_o
);
  import rrss_pkg::*;

  logic [7:0]            time_slice_q;
  in_item_t              item_q;
  action_e               act;
  logic                  is_fork;

  logic [SLOT_W-1:0]     cur_q;
  logic [SLOT_W-1:0]     idx_q;
  logic [SLOT_W-1:0]     raddr_q;
  logic [SLOT_W-1:0]     found_idx_q;
  logic                  found_q;
  logic                  proc_q;
  logic                  charge_q;
  slot_entry_t           cache_q;
  logic [OUT_SLOT_W-1:0] new_slot_q;
  logic                  failed_q;

  // slot table
  slot_entry_t           mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  valid_q;
  slot_entry_t           rdata_q;
  logic                  rvalid_q;
  slot_entry_t           rd_entry;

  logic                  re;
  logic [SLOT_W-1:0]     raddr;
  logic                  we;
  logic [SLOT_W-1:0]     waddr;
  slot_entry_t           wdata;

  slot_entry_t           ld_entry;
  slot_entry_t           ld_cache;
  logic                  ld_charge;
  slot_entry_t           wake_entry;
  logic [15:0]           sleep_dec;
  logic                  hit;
  logic [SLOT_W-1:0]     pick;

  assign act     = action_e'(item_q.action);
  assign is_fork = (act == ACT_FORK);

  // never written entries read as their reset contents
  assign rd_entry = rvalid_q ? rdata_q : reset_entry(raddr_q);

  // current slot after the action, and slice charge or preemption
  always_comb begin
    ld_entry = rd_entry;
    case (act)
      ACT_SLEEP: begin
        ld_entry.state      = ST_BLOCKED;
        ld_entry.sleep_left = item_q.sleep_ticks;
      end
      ACT_EXIT: begin
        ld_entry.state = ST_DEAD;
      end
      default: begin
        ld_entry = rd_entry;
      end
    endcase
    ld_charge = (ld_entry.state == ST_RUNNING) && (ld_entry.slice_used != time_slice_q);
    ld_cache  = ld_entry;
    if (!is_fork) begin
      if (ld_charge) begin
        ld_cache.slice_used = ld_entry.slice_used + 8'd1;
      end else if (ld_entry.state == ST_RUNNING) begin
        ld_cache.state      = ST_RUNNABLE;
        ld_cache.slice_used = '0;
      end
    end
  end

  // sleep countdown of one scanned slot
  always_comb begin
    wake_entry = rd_entry;
    sleep_dec  = rd_entry.sleep_left - 16'd1;
    if (rd_entry.state == ST_BLOCKED) begin
      wake_entry.sleep_left = sleep_dec;
      if (sleep_dec == '0) begin
        wake_entry.state = ST_RUNNABLE;
      end
    end
  end

  // dead slot for fork, runnable non-idle slot for a switch
  assign hit = is_fork ? (rd_entry.state == ST_DEAD)
                       : ((wake_entry.state == ST_RUNNABLE) && (raddr_q != '0));

  // selected slot, falling back to the old current slot or idle slot 0
  assign pick = found_q ? found_idx_q
                        : ((cache_q.state == ST_RUNNABLE) ? cur_q : '0);

  // read port selection
  assign re    = cmd_i.rd_cur | cmd_i.scan_rd | cmd_i.rd_pick;
  assign raddr = cmd_i.rd_cur ? cur_q : (cmd_i.scan_rd ? idx_q : pick);

  // write port selection
  always_comb begin
    we    = 1'b0;
    waddr = raddr_q;
    wdata = wake_entry;
    if (proc_q && !is_fork) begin
      we = 1'b1;
    end else if (cmd_i.wr_cur) begin
      we    = 1'b1;
      waddr = cur_q;
      wdata = cache_q;
    end else if (cmd_i.wr_pick) begin
      we               = 1'b1;
      waddr            = raddr_q;
      wdata.state      = ST_RUNNING;
      wdata.sleep_left = rd_entry.sleep_left;
      wdata.slice_used = 8'd1;
    end else if (cmd_i.fork_wr && found_q) begin
      we               = 1'b1;
      waddr            = found_idx_q;
      wdata.state      = ST_RUNNABLE;
      wdata.sleep_left = cache_q.sleep_left;
      wdata.slice_used = cache_q.slice_used;
    end
  end

  // table storage and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q  <= mem_q[raddr];
      rvalid_q <= valid_q[raddr];
      raddr_q  <= raddr;
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= item_i;
    end
    if (cmd_i.load) begin
      cache_q  <= ld_cache;
      charge_q <= ld_charge;
      idx_q    <= is_fork ? '0 : next_slot(cur_q);
    end else if (cmd_i.scan_rd) begin
      idx_q <= next_slot(idx_q);
    end
    if (proc_q && hit && !found_q) begin
      found_idx_q <= raddr_q;
    end
  end

  // control state, configuration and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_slice_q <= TIME_SLICE_RST;
      cur_q        <= '0;
      valid_q      <= '0;
      proc_q       <= 1'b0;
      found_q      <= 1'b0;
      new_slot_q   <= '0;
      failed_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        time_slice_q <= cfg_wdata_i;
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      proc_q <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        new_slot_q <= '0;
        failed_q   <= 1'b0;
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (proc_q && hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.wr_pick) begin
        cur_q <= raddr_q;
      end
      if (cmd_i.fork_wr) begin
        if (found_q) begin
          new_slot_q <= to_out_slot(found_idx_q);
        end else begin
          failed_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.action     = act;
  assign status_o.ticks_zero = (item_q.sleep_ticks == '0);
  assign status_o.charge     = charge_q;

  assign result_o.running_slot = to_out_slot(cur_q);
  assign result_o.new_slot     = new_slot_q;
  assign result_o.failed       = failed_q;

endmodule

// File: rtl/round_robin_sleep_scheduler_unit.sv
// a tick, sleep or exit scans the slot table, then charges the slice or switches slots;
// a fork scans it for a dead slot, and a sleep of zero ticks skips the scan.
// the slot table scan reads one entry a cycle on its single read port.
// throughput: one item at a time, the next start is taken the cycle after done_o.
// reset: slot 0 running, all other slots dead, time slice 16; the table needs no clearing.
// the result is valid with the one-cycle done_o strobe, holds until the next item is accepted and cannot be stalled.
module round_robin_sleep_scheduler_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  rrss_pkg::in_item_t  item_i,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  output logic                done_o,
  output rrss_pkg::out_item_t result_o
);
  import rrss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing of the table passes
  rrss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // slot table and scheduling arithmetic
  rrss_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule

// File: rtl/rrss_checker.sv
module rrss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input rrss_pkg::out_item_t result_o
);
  import rrss_pkg::*;

  // an accepted transfer keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transfer");

  // a result only while an item is in work
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // one result per item, then idle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe not followed by idle");

  // a failed fork claims no slot
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.failed) |-> (result_o.new_slot == '0))
    else $error("failed fork reports a new slot");

endmodule

bind round_robin_sleep_scheduler_unit rrss_checker u_rrss_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rrss_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  in_item_t   item_i      = '0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic       busy;
  logic       done_o;
  out_item_t  result_o;

  round_robin_sleep_scheduler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .busy        (busy),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // commands waiting for transfer and results predicted for accepted commands
  in_item_t  pending_cmds [$];
  out_item_t predicted_res [$];
  int        idle_pct   = 0;
  int        mismatches = 0;

  // scheduler shadow state
  slot_state_e task_state [NUM_SLOTS];
  logic [15:0] sleep_cnt  [NUM_SLOTS];
  logic [7:0]  slice_cnt  [NUM_SLOTS];
  int unsigned cur_slot;
  logic [7:0]  slice_len;

  // one scheduler tick: wake sleepers, charge the slice or switch task
  function automatic void sched_tick();
    int unsigned c, j, pick;
    c = cur_slot;
    for (j = (c + 1) % NUM_SLOTS; j != c; j = (j + 1) % NUM_SLOTS) begin
      if (task_state[j] == ST_BLOCKED) begin
        sleep_cnt[j] = sleep_cnt[j] - 16'd1;
        if (sleep_cnt[j] == 16'd0) task_state[j] = ST_RUNNABLE;
      end
    end
    if (task_state[c] == ST_RUNNING && slice_cnt[c] != slice_len) begin
      slice_cnt[c] = slice_cnt[c] + 8'd1;
      return;
    end
    if (task_state[c] == ST_RUNNING) begin
      task_state[c] = ST_RUNNABLE;
      slice_cnt[c]  = '0;
    end
    // round robin pick from the slot after the current one, never slot 0
    pick = c;
    for (j = (c + 1) % NUM_SLOTS; j != c; j = (j + 1) % NUM_SLOTS) begin
      if (pick == c && j != 0 && task_state[j] == ST_RUNNABLE) pick = j;
    end
    // idle slot 0 is forced to run when nothing else can
    if (task_state[pick] != ST_RUNNABLE) pick = 0;
    cur_slot         = pick;
    task_state[pick] = ST_RUNNING;
    slice_cnt[pick]  = 8'd1;
  endfunction

  // apply one command to the shadow state and return its result
  function automatic out_item_t sched_step(in_item_t cmd);
    out_item_t   res;
    int unsigned par;
    int          claim;
    par   = cur_slot;
    claim = -1;
    res   = '0;
    case (cmd.action)
      ACT_TICK: sched_tick();
      ACT_SLEEP: begin
        if (cmd.sleep_ticks != 16'd0) begin
          task_state[par] = ST_BLOCKED;
          sleep_cnt[par]  = cmd.sleep_ticks;
          sched_tick();
        end
      end
      ACT_EXIT: begin
        task_state[par] = ST_DEAD;
        sched_tick();
      end
      default: begin
        // fork takes the lowest dead slot and inherits the parent's counts
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (claim < 0 && task_state[k] == ST_DEAD) claim = k;
        end
        if (claim >= 0) begin
          task_state[claim] = ST_RUNNABLE;
          slice_cnt[claim]  = slice_cnt[par];
          sleep_cnt[claim]  = sleep_cnt[par];
          res.new_slot      = OUT_SLOT_W'(claim);
        end else begin
          res.failed = 1'b1;
        end
      end
    endcase
    res.running_slot = OUT_SLOT_W'(cur_slot);
    return res;
  endfunction

  // random command with a weighted mix of actions
  function automatic in_item_t rand_cmd(int fork_w, int exit_w);
    in_item_t cmd;
    int       r;
    cmd.sleep_ticks = 16'($urandom);
    r = $urandom_range(99);
    if (r < fork_w) begin
      cmd.action = ACT_FORK;
    end else if (r < fork_w + exit_w) begin
      cmd.action = ACT_EXIT;
    end else if (r < fork_w + exit_w + 22) begin
      cmd.action = ACT_SLEEP;
      r = $urandom_range(99);
      if (r < 5) cmd.sleep_ticks = '0;
      else if (r >= 8) cmd.sleep_ticks = 16'($urandom_range(24, 1));
    end else begin
      cmd.action = ACT_TICK;
    end
    return cmd;
  endfunction

  function automatic void queue_cmd(action_e act, logic [15:0] ticks);
    in_item_t cmd;
    cmd.action      = act;
    cmd.sleep_ticks = ticks;
    pending_cmds.push_back(cmd);
  endfunction

  task automatic report(string fld, logic [3:0] want, logic [3:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || predicted_res.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_slice(logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    slice_len = val;
    @(negedge clk_i);
  endtask

  // one random phase; a nonzero chunk makes the sender wait for all results
  task automatic run_phase(logic [7:0] slice, int idle, int n, int fork_w, int exit_w,
                           int chunk);
    write_slice(slice);
    idle_pct = idle;
    for (int i = 1; i <= n; i++) begin
      pending_cmds.push_back(rand_cmd(fork_w, exit_w));
      if (chunk > 0 && i % chunk == 0) wait_drained();
    end
    wait_drained();
  endtask

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // driver: present the head command, predict on transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predicted_res.push_back(sched_step(item_i));
        void'(pending_cmds.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start  <= 1'b1;
          item_i <= pending_cmds[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && done_o) begin
      if (predicted_res.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got slot %0d new %0d failed %0d",
                 $time, result_o.running_slot, result_o.new_slot, result_o.failed);
      end else begin
        want = predicted_res.pop_front();
        if (result_o.running_slot !== want.running_slot)
          report("running_slot", want.running_slot, result_o.running_slot);
        if (result_o.new_slot !== want.new_slot)
          report("new_slot", want.new_slot, result_o.new_slot);
        if (result_o.failed !== want.failed)
          report("failed", {3'b0, want.failed}, {3'b0, result_o.failed});
      end
    end
  end

  // stimulus
  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      task_state[s] = (s == 0) ? ST_RUNNING : ST_DEAD;
      sleep_cnt[s]  = '0;
      slice_cnt[s]  = '0;
    end
    cur_slot  = 0;
    slice_len = TIME_SLICE_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero sleep, forks, sleep and wake, exits down to idle slot 0
    queue_cmd(ACT_TICK,  16'h0000);
    queue_cmd(ACT_SLEEP, 16'h0000);
    queue_cmd(ACT_FORK,  16'h0000);
    queue_cmd(ACT_FORK,  16'hFFFF);
    queue_cmd(ACT_SLEEP, 16'd3);
    queue_cmd(ACT_TICK,  16'hFFFF);
    queue_cmd(ACT_TICK,  16'h0000);
    queue_cmd(ACT_TICK,  16'h5A5A);
    queue_cmd(ACT_EXIT,  16'hA5A5);
    queue_cmd(ACT_FORK,  16'h0000);
    queue_cmd(ACT_SLEEP, 16'd1);
    queue_cmd(ACT_TICK,  16'h0000);
    queue_cmd(ACT_SLEEP, 16'hFFFF);
    queue_cmd(ACT_TICK,  16'h0000);
    queue_cmd(ACT_EXIT,  16'h0000);
    queue_cmd(ACT_EXIT,  16'h0000);
    queue_cmd(ACT_EXIT,  16'h0000);
    queue_cmd(ACT_EXIT,  16'h0000);
    queue_cmd(ACT_TICK,  16'h0000);
    queue_cmd(ACT_FORK,  16'h0000);
    queue_cmd(ACT_TICK,  16'h0000);
    wait_drained();

    // random phases over several slice lengths and idle rates
    run_phase(8'd1,   49, 110, 23, 12, 0);
    run_phase(8'd255, 29, 100, 23, 10, 0);
    run_phase(8'd0,    0, 100, 23, 10, 0);
    run_phase(8'd16,  49, 110, 23, 12, 7);
    run_phase(8'd3,   29, 110, 40,  5, 0);
    run_phase(8'd2,    0, 100, 20, 15, 0);

    // let any stray result show before the verdict
    repeat (NUM_SLOTS + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
